// ===== rtl/core/nphs_pkg.sv =====
// ---------------------------------------------------------------------------
// nphs_pkg
// Shared types, constants and the arctangent table of the nearest point
// haversine search block.
// ---------------------------------------------------------------------------
package nphs_pkg;

	// Field widths.
	localparam int TAG_W   = 16;
	localparam int LAT_W   = 30;
	localparam int LON_W   = 31;
	localparam int DIST_W  = 23;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W   = 31;

	// Internal widths.
	localparam int ANG_W   = 35;
	localparam int XW      = 34;
	localparam int MW      = 36;
	localparam int IT_W    = 5;
	localparam int SQ_W    = 64;
	localparam int SQ_ITERS = 32;
	localparam int CORDIC_MAX = 32;

	localparam int CORDIC_STEPS_DEF = 24;

	// Input command codes.
	localparam logic CMD_ZONE = 1'b0;
	localparam logic CMD_END  = 1'b1;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_USER_LATITUDE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_USER_LONGITUDE = 2'd1;

	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LATCH,
		OP_EMIT,
		OP_MUL_LD,
		OP_MUL,
		OP_MUL_POST,
		OP_RED,
		OP_ROT,
		OP_ROT_ST,
		OP_SQ_INIT,
		OP_SQ,
		OP_SQ_ST,
		OP_VEC_INIT,
		OP_VEC,
		OP_UPDATE
	} dp_op_t;

	// Multiplier jobs, in the order they run for one zone record.
	typedef enum logic [3:0] {
		J_RAD0,
		J_RAD1,
		J_RAD2,
		J_RAD3,
		J_M1,
		J_M2,
		J_M3,
		J_M4,
		J_DIST
	} job_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LD,
		S_MUL,
		S_POST,
		S_RED,
		S_ROT,
		S_RST,
		S_SQI,
		S_SQ,
		S_SQS,
		S_VECI,
		S_VEC,
		S_UPD
	} state_t;

	typedef struct packed {
		dp_op_t op;
		job_t   job;
		logic   sq_x;
	} dp_cmd_t;

	typedef struct packed {
		logic red_done;
		logic cordic_last;
		logic sqrt_last;
		logic out_busy;
	} dp_stat_t;

	// atan(2^-i) in Q30 radians.
	function automatic logic [30:0] atan_q30(input logic [IT_W-1:0] i);
		logic [30:0] v;
		case (i)
			5'd0:  v = 31'h3243F6A8;
			5'd1:  v = 31'h1DAC6705;
			5'd2:  v = 31'h0FADBAFC;
			5'd3:  v = 31'h07F56EA6;
			5'd4:  v = 31'h03FEAB76;
			5'd5:  v = 31'h01FFD55B;
			5'd6:  v = 31'h00FFFAAA;
			5'd7:  v = 31'h007FFF55;
			5'd8:  v = 31'h003FFFEA;
			5'd9:  v = 31'h001FFFFD;
			5'd10: v = 31'h000FFFFF;
			5'd11: v = 31'h0007FFFF;
			5'd12: v = 31'h0003FFFF;
			5'd13: v = 31'h0001FFFF;
			5'd14: v = 31'h0000FFFF;
			5'd15: v = 31'h00007FFF;
			5'd16: v = 31'h00003FFF;
			5'd17: v = 31'h00001FFF;
			5'd18: v = 31'h00000FFF;
			5'd19: v = 31'h000007FF;
			5'd20: v = 31'h000003FF;
			5'd21: v = 31'h000001FF;
			5'd22: v = 31'h000000FF;
			5'd23: v = 31'h0000007F;
			5'd24: v = 31'h0000003F;
			5'd25: v = 31'h0000001F;
			5'd26: v = 31'h0000000F;
			5'd27: v = 31'h00000008;
			5'd28: v = 31'h00000004;
			5'd29: v = 31'h00000002;
			5'd30: v = 31'h00000001;
			default: v = 31'h00000000;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/core/nphs_ctrl.sv =====
// ---------------------------------------------------------------------------
// nphs_ctrl
// Sequencer that steps the datapath through the distance computation of one
// zone record and accepts input transactions.
// ---------------------------------------------------------------------------
module nphs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               zone_valid,
	input  logic               cmd,
	output logic               zone_stall,
	input  nphs_pkg::dp_stat_t stat,
	output nphs_pkg::dp_cmd_t  dcmd
);

	nphs_pkg::state_t state_q, state_d;
	nphs_pkg::job_t   job_q, job_d;
	logic             sqx_q, sqx_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nphs_pkg::S_IDLE;
			job_q   <= nphs_pkg::J_RAD0;
			sqx_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			job_q   <= job_d;
			sqx_q   <= sqx_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		job_d    = job_q;
		sqx_d    = sqx_q;
		dcmd.op  = nphs_pkg::OP_NONE;
		dcmd.job = job_q;
		dcmd.sq_x = sqx_q;
		zone_stall = 1'b1;
		unique case (state_q)
			nphs_pkg::S_IDLE: begin
				// An end item waits until the previous result is taken.
				zone_stall = (cmd == nphs_pkg::CMD_END) && stat.out_busy;
				if (zone_valid && !zone_stall) begin
					if (cmd == nphs_pkg::CMD_ZONE) begin
						dcmd.op = nphs_pkg::OP_LATCH;
						job_d   = nphs_pkg::J_RAD0;
						state_d = nphs_pkg::S_LD;
					end else begin
						dcmd.op = nphs_pkg::OP_EMIT;
					end
				end
			end
			nphs_pkg::S_LD: begin
				dcmd.op = nphs_pkg::OP_MUL_LD;
				state_d = nphs_pkg::S_MUL;
			end
			nphs_pkg::S_MUL: begin
				dcmd.op = nphs_pkg::OP_MUL;
				state_d = nphs_pkg::S_POST;
			end
			nphs_pkg::S_POST: begin
				dcmd.op = nphs_pkg::OP_MUL_POST;
				unique case (job_q) inside
					nphs_pkg::J_RAD0, nphs_pkg::J_RAD1,
					nphs_pkg::J_RAD2, nphs_pkg::J_RAD3: state_d = nphs_pkg::S_RED;
					nphs_pkg::J_M4: begin
						sqx_d   = 1'b0;
						state_d = nphs_pkg::S_SQI;
					end
					nphs_pkg::J_DIST: state_d = nphs_pkg::S_UPD;
					default: begin
						job_d   = nphs_pkg::job_t'(job_q + 4'd1);
						state_d = nphs_pkg::S_LD;
					end
				endcase
			end
			nphs_pkg::S_RED: begin
				dcmd.op = nphs_pkg::OP_RED;
				if (stat.red_done) state_d = nphs_pkg::S_ROT;
			end
			nphs_pkg::S_ROT: begin
				dcmd.op = nphs_pkg::OP_ROT;
				if (stat.cordic_last) state_d = nphs_pkg::S_RST;
			end
			nphs_pkg::S_RST: begin
				dcmd.op = nphs_pkg::OP_ROT_ST;
				job_d   = nphs_pkg::job_t'(job_q + 4'd1);
				state_d = nphs_pkg::S_LD;
			end
			nphs_pkg::S_SQI: begin
				dcmd.op = nphs_pkg::OP_SQ_INIT;
				state_d = nphs_pkg::S_SQ;
			end
			nphs_pkg::S_SQ: begin
				dcmd.op = nphs_pkg::OP_SQ;
				if (stat.sqrt_last) state_d = nphs_pkg::S_SQS;
			end
			nphs_pkg::S_SQS: begin
				dcmd.op = nphs_pkg::OP_SQ_ST;
				if (sqx_q) begin
					state_d = nphs_pkg::S_VECI;
				end else begin
					sqx_d   = 1'b1;
					state_d = nphs_pkg::S_SQI;
				end
			end
			nphs_pkg::S_VECI: begin
				dcmd.op = nphs_pkg::OP_VEC_INIT;
				state_d = nphs_pkg::S_VEC;
			end
			nphs_pkg::S_VEC: begin
				dcmd.op = nphs_pkg::OP_VEC;
				if (stat.cordic_last) begin
					job_d   = nphs_pkg::J_DIST;
					state_d = nphs_pkg::S_LD;
				end
			end
			nphs_pkg::S_UPD: begin
				dcmd.op = nphs_pkg::OP_UPDATE;
				state_d = nphs_pkg::S_IDLE;
			end
			default: state_d = nphs_pkg::S_IDLE;
		endcase
	end

endmodule

// ===== rtl/core/nphs_dp.sv =====
// ---------------------------------------------------------------------------
// nphs_dp
// Datapath: shared multiplier, shared CORDIC stage, bit-serial square root,
// configuration registers, search state and the result register.
// ---------------------------------------------------------------------------
module nphs_dp #(
	parameter int CORDIC_STEPS = nphs_pkg::CORDIC_STEPS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  nphs_pkg::dp_cmd_t                   dcmd,
	output nphs_pkg::dp_stat_t                  stat,
	input  logic [nphs_pkg::TAG_W-1:0]          zone_tag,
	input  logic signed [nphs_pkg::LAT_W-1:0]   zone_latitude,
	input  logic signed [nphs_pkg::LON_W-1:0]   zone_longitude,
	input  logic                                cfg_valid,
	input  logic [nphs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [nphs_pkg::CFG_W-1:0]          cfg_data,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic                                found,
	output logic [nphs_pkg::TAG_W-1:0]          nearest_tag,
	output logic [nphs_pkg::DIST_W-1:0]         nearest_distance
);

	localparam int ANG_W = nphs_pkg::ANG_W;
	localparam int XW    = nphs_pkg::XW;
	localparam int MW    = nphs_pkg::MW;
	localparam int IT_W  = nphs_pkg::IT_W;
	localparam int SQ_W  = nphs_pkg::SQ_W;
	localparam int NSTEPS = (CORDIC_STEPS < nphs_pkg::CORDIC_MAX) ?
		CORDIC_STEPS : nphs_pkg::CORDIC_MAX;

	localparam logic signed [ANG_W-1:0] PI_Q     = 35'sd3373259426;
	localparam logic signed [ANG_W-1:0] HALF_PI_Q = 35'sd1686629713;
	localparam logic signed [ANG_W-1:0] TWO_PI_Q = 35'sd6746518852;
	localparam logic signed [XW-1:0]    INV_GAIN = 34'sd652032874;
	localparam logic signed [MW-1:0]    DEG2RAD  = 36'sd74961321;
	localparam logic signed [MW-1:0]    DSCALE   = 36'sd3261952;
	localparam logic [30:0]             Q30_ONE  = 31'd1073741824;
	localparam logic [33:0]             DIST_MAX_EXT = 34'(nphs_pkg::DIST_MAX);

	// Configuration and search state.
	logic signed [nphs_pkg::LAT_W-1:0]  ulat_q;
	logic signed [nphs_pkg::LON_W-1:0]  ulon_q;
	logic [nphs_pkg::DIST_W-1:0]        best_dist_q;
	logic [nphs_pkg::TAG_W-1:0]         best_tag_q;
	logic                               any_q;
	logic                               out_valid_q;
	logic                               found_q;
	logic [nphs_pkg::TAG_W-1:0]         ntag_q;
	logic [nphs_pkg::DIST_W-1:0]        ndist_q;

	// Working registers.
	logic [nphs_pkg::TAG_W-1:0]         tag_q;
	logic signed [nphs_pkg::LAT_W-1:0]  zlat_q;
	logic signed [nphs_pkg::LON_W-1:0]  zlon_q;
	logic [31:0]                        mul_a_q, mul_b_q;
	logic                               mul_neg_q;
	logic [63:0]                        prod_q;
	logic signed [ANG_W-1:0]            ang_q;
	logic signed [XW-1:0]               x_q, y_q, z_q;
	logic                               negc_q;
	logic [IT_W-1:0]                    it_q;
	logic signed [XW-1:0]               s1_q, s2_q, cl1_q, cl2_q;
	logic signed [MW-1:0]               m1_q, m2_q, m3_q;
	logic [30:0]                        a_q, sy_q, sx_q;
	logic [SQ_W-1:0]                    sq_n_q, sq_res_q, sq_bit_q;
	logic [nphs_pkg::DIST_W-1:0]        dist_q;

	// Operand selection for the shared multiplier.
	logic signed [MW-1:0] opa, opb, abs_a, abs_b;
	logic signed [XW-1:0] z_pos;

	always_comb begin
		z_pos = z_q[XW-1] ? '0 : z_q;
		case (dcmd.job)
			nphs_pkg::J_RAD0: begin
				opa = MW'(zlat_q) - MW'(ulat_q);
				opb = DEG2RAD;
			end
			nphs_pkg::J_RAD1: begin
				opa = MW'(zlon_q) - MW'(ulon_q);
				opb = DEG2RAD;
			end
			nphs_pkg::J_RAD2: begin
				opa = MW'(ulat_q);
				opb = DEG2RAD;
			end
			nphs_pkg::J_RAD3: begin
				opa = MW'(zlat_q);
				opb = DEG2RAD;
			end
			nphs_pkg::J_M1: begin
				opa = MW'(s1_q);
				opb = MW'(s1_q);
			end
			nphs_pkg::J_M2: begin
				opa = MW'(cl1_q);
				opb = MW'(cl2_q);
			end
			nphs_pkg::J_M3: begin
				opa = MW'(s2_q);
				opb = MW'(s2_q);
			end
			nphs_pkg::J_M4: begin
				opa = m2_q;
				opb = m3_q;
			end
			default: begin
				opa = MW'(z_pos);
				opb = DSCALE;
			end
		endcase
		abs_a = opa[MW-1] ? -opa : opa;
		abs_b = opb[MW-1] ? -opb : opb;
	end

	// Rounding after the product register (half away from zero on magnitude).
	logic [63:0]             sum24, sum25, sum30;
	logic [ANG_W-1:0]        rmag;
	logic signed [ANG_W-1:0] ang_new;
	logic [33:0]             r30;
	logic signed [MW-1:0]    mres;
	logic signed [MW:0]      a_sum;
	logic [30:0]             a_clamp;
	logic [nphs_pkg::DIST_W-1:0] d_sat;

	always_comb begin
		sum24 = prod_q + (64'd1 << 23);
		sum25 = prod_q + (64'd1 << 24);
		sum30 = prod_q + (64'd1 << 29);
		if (dcmd.job == nphs_pkg::J_RAD2 || dcmd.job == nphs_pkg::J_RAD3) begin
			rmag = sum24[58:24];
		end else begin
			rmag = sum25[59:25];
		end
		ang_new = mul_neg_q ? -$signed(rmag) : $signed(rmag);
		r30  = sum30[63:30];
		mres = mul_neg_q ? -$signed({2'b00, r30}) : $signed({2'b00, r30});
		a_sum = (MW+1)'(m1_q) + (MW+1)'(mres);
		if (a_sum < 0) begin
			a_clamp = '0;
		end else if (a_sum > $signed({6'd0, Q30_ONE})) begin
			a_clamp = Q30_ONE;
		end else begin
			a_clamp = a_sum[30:0];
		end
		d_sat = (r30 > DIST_MAX_EXT) ? nphs_pkg::DIST_MAX : r30[nphs_pkg::DIST_W-1:0];
	end

	// Shared CORDIC micro-rotation.
	logic signed [XW-1:0] dx, dy, at;
	logic signed [XW-1:0] x_rot, y_rot, z_rot, x_vec, y_vec, z_vec;

	always_comb begin
		dx = y_q >>> it_q;
		dy = x_q >>> it_q;
		at = XW'($signed({1'b0, nphs_pkg::atan_q30(it_q)}));
		if (!z_q[XW-1]) begin
			x_rot = x_q - dx;
			y_rot = y_q + dy;
			z_rot = z_q - at;
		end else begin
			x_rot = x_q + dx;
			y_rot = y_q - dy;
			z_rot = z_q + at;
		end
		if (!y_q[XW-1]) begin
			x_vec = x_q + dx;
			y_vec = y_q - dy;
			z_vec = z_q + at;
		end else begin
			x_vec = x_q - dx;
			y_vec = y_q + dy;
			z_vec = z_q - at;
		end
	end

	// Angle range reduction and quadrant fold.
	logic ang_hi, ang_lo;
	logic signed [ANG_W-1:0] fold_z;
	logic                    fold_neg;

	always_comb begin
		ang_hi = ang_q > PI_Q;
		ang_lo = ang_q < -PI_Q;
		if (ang_q > HALF_PI_Q) begin
			fold_z   = PI_Q - ang_q;
			fold_neg = 1'b1;
		end else if (ang_q < -HALF_PI_Q) begin
			fold_z   = -PI_Q - ang_q;
			fold_neg = 1'b1;
		end else begin
			fold_z   = ang_q;
			fold_neg = 1'b0;
		end
	end

	// Square root trial subtraction.
	logic [SQ_W-1:0] sq_trial;
	logic            sq_ge;
	logic signed [XW-1:0] cos_out;

	assign sq_trial = sq_res_q + sq_bit_q;
	assign sq_ge    = sq_n_q >= sq_trial;
	assign cos_out  = negc_q ? -x_q : x_q;

	always_ff @(posedge clk) begin
		unique case (dcmd.op)
			nphs_pkg::OP_LATCH: begin
				tag_q  <= zone_tag;
				zlat_q <= zone_latitude;
				zlon_q <= zone_longitude;
			end
			nphs_pkg::OP_MUL_LD: begin
				mul_a_q   <= abs_a[31:0];
				mul_b_q   <= abs_b[31:0];
				mul_neg_q <= opa[MW-1] ^ opb[MW-1];
			end
			nphs_pkg::OP_MUL: begin
				prod_q <= 64'(mul_a_q) * 64'(mul_b_q);
			end
			nphs_pkg::OP_MUL_POST: begin
				case (dcmd.job)
					nphs_pkg::J_M1: m1_q <= mres;
					nphs_pkg::J_M2: m2_q <= mres;
					nphs_pkg::J_M3: m3_q <= mres;
					nphs_pkg::J_M4: a_q <= a_clamp;
					nphs_pkg::J_DIST: dist_q <= d_sat;
					default: ang_q <= ang_new;
				endcase
			end
			nphs_pkg::OP_RED: begin
				if (ang_hi) begin
					ang_q <= ang_q - TWO_PI_Q;
				end else if (ang_lo) begin
					ang_q <= ang_q + TWO_PI_Q;
				end else begin
					z_q    <= XW'(fold_z);
					negc_q <= fold_neg;
					x_q    <= INV_GAIN;
					y_q    <= '0;
					it_q   <= '0;
				end
			end
			nphs_pkg::OP_ROT: begin
				x_q  <= x_rot;
				y_q  <= y_rot;
				z_q  <= z_rot;
				it_q <= it_q + 1'b1;
			end
			nphs_pkg::OP_ROT_ST: begin
				case (dcmd.job)
					nphs_pkg::J_RAD0: s1_q  <= y_q;
					nphs_pkg::J_RAD1: s2_q  <= y_q;
					nphs_pkg::J_RAD2: cl1_q <= cos_out;
					default:          cl2_q <= cos_out;
				endcase
			end
			nphs_pkg::OP_SQ_INIT: begin
				if (dcmd.sq_x) begin
					sq_n_q <= SQ_W'({Q30_ONE - a_q, 30'd0});
				end else begin
					sq_n_q <= SQ_W'({a_q, 30'd0});
				end
				sq_res_q <= '0;
				sq_bit_q <= SQ_W'(1) << 62;
				it_q     <= '0;
			end
			nphs_pkg::OP_SQ: begin
				if (sq_ge) begin
					sq_n_q   <= sq_n_q - sq_trial;
					sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
				end else begin
					sq_res_q <= sq_res_q >> 1;
				end
				sq_bit_q <= sq_bit_q >> 2;
				it_q     <= it_q + 1'b1;
			end
			nphs_pkg::OP_SQ_ST: begin
				if (dcmd.sq_x) begin
					sx_q <= sq_res_q[30:0];
				end else begin
					sy_q <= sq_res_q[30:0];
				end
			end
			nphs_pkg::OP_VEC_INIT: begin
				x_q  <= XW'($signed({1'b0, sx_q}));
				y_q  <= XW'($signed({1'b0, sy_q}));
				z_q  <= '0;
				it_q <= '0;
			end
			nphs_pkg::OP_VEC: begin
				x_q  <= x_vec;
				y_q  <= y_vec;
				z_q  <= z_vec;
				it_q <= it_q + 1'b1;
			end
			default: ;
		endcase
	end

	// Configuration, search state and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ulat_q      <= '0;
			ulon_q      <= '0;
			best_dist_q <= nphs_pkg::DIST_MAX;
			best_tag_q  <= '0;
			any_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					nphs_pkg::REG_USER_LATITUDE:  ulat_q <= cfg_data[nphs_pkg::LAT_W-1:0];
					nphs_pkg::REG_USER_LONGITUDE: ulon_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid_q && !result_stall) out_valid_q <= 1'b0;
			if (dcmd.op == nphs_pkg::OP_EMIT) begin
				out_valid_q <= 1'b1;
				best_dist_q <= nphs_pkg::DIST_MAX;
				best_tag_q  <= '0;
				any_q       <= 1'b0;
			end else if (dcmd.op == nphs_pkg::OP_UPDATE) begin
				if (!any_q || dist_q < best_dist_q) begin
					best_dist_q <= dist_q;
					best_tag_q  <= tag_q;
				end
				any_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dcmd.op == nphs_pkg::OP_EMIT) begin
			found_q <= any_q;
			ntag_q  <= any_q ? best_tag_q : '0;
			ndist_q <= any_q ? best_dist_q : '0;
		end
	end

	assign stat.red_done    = !ang_hi && !ang_lo;
	assign stat.cordic_last = it_q == IT_W'(NSTEPS - 1);
	assign stat.sqrt_last   = it_q == IT_W'(nphs_pkg::SQ_ITERS - 1);
	assign stat.out_busy    = out_valid_q;

	assign result_valid     = out_valid_q;
	assign found            = found_q;
	assign nearest_tag      = ntag_q;
	assign nearest_distance = ndist_q;

endmodule

// ===== rtl/core/nearest_point_haversine_search.sv =====
// ---------------------------------------------------------------------------
// nearest_point_haversine_search
// Streams zone records, computes the haversine distance of each one from the
// configured user position and reports the nearest zone at end of list.
// ---------------------------------------------------------------------------
//
//  Channel  Handshake              Payload
//  zone     zone_valid/zone_stall  cmd, zone_tag, zone_latitude, zone_longitude
//  result   result_valid/result_stall  found, nearest_tag, nearest_distance
//  cfg      cfg_valid/cfg_ready    cfg_index, cfg_data
//
// A zone record occupies the block for four sine/cosine CORDIC runs, two
// 32-step square roots and one vectoring CORDIC run, all on one shared
// iteration unit and one multiplier. The half longitude difference is
// wrapped back into [-pi, pi] when it lies outside that range.
// An end-of-list transaction loads the result register.
// The result register parts the two sides: zone records are accepted while a
// result waits, and only an end-of-list item is stalled until it is taken.
// Reset clears the user position to zero and the search state to empty.
//
module nearest_point_haversine_search #(
	parameter int CORDIC_STEPS = nphs_pkg::CORDIC_STEPS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Zone record channel.
	input  logic                                zone_valid,
	output logic                                zone_stall,
	input  logic                                cmd,
	input  logic [nphs_pkg::TAG_W-1:0]          zone_tag,
	input  logic signed [nphs_pkg::LAT_W-1:0]   zone_latitude,
	input  logic signed [nphs_pkg::LON_W-1:0]   zone_longitude,
	// Result channel.
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic                                found,
	output logic [nphs_pkg::TAG_W-1:0]          nearest_tag,
	output logic [nphs_pkg::DIST_W-1:0]         nearest_distance,
	// Configuration write channel; it is always ready.
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [nphs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [nphs_pkg::CFG_W-1:0]          cfg_data
);

	nphs_pkg::dp_cmd_t  dcmd;
	nphs_pkg::dp_stat_t stat;

	// Register writes never wait; the datapath takes them in the same cycle.
	assign cfg_ready = 1'b1;

	// The controller owns the input handshake and sequences the datapath.
	nphs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.zone_valid (zone_valid),
		.cmd        (cmd),
		.zone_stall (zone_stall),
		.stat       (stat),
		.dcmd       (dcmd)
	);

	// The datapath holds the arithmetic, the best-so-far state and the
	// result register with its output handshake.
	nphs_dp #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.dcmd             (dcmd),
		.stat             (stat),
		.zone_tag         (zone_tag),
		.zone_latitude    (zone_latitude),
		.zone_longitude   (zone_longitude),
		.cfg_valid        (cfg_valid & cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.found            (found),
		.nearest_tag      (nearest_tag),
		.nearest_distance (nearest_distance)
	);

endmodule
